@@ rtl/tlvp_pkg.sv @@
// Shared types and codes for the TLV message parser.
`timescale 1ns / 1ps

package tlvp_pkg;

    // Parser phase, one-hot
    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_TYPE   = 7'b0000010,
        PH_LEN_LO = 7'b0000100,
        PH_LEN_HI = 7'b0001000,
        PH_DATA   = 7'b0010000,
        PH_TRAIL  = 7'b0100000,
        PH_ERROR  = 7'b1000000
    } phase_t;

    // Byte role codes
    localparam logic [2:0] ROLE_HEADER   = 3'd0;
    localparam logic [2:0] ROLE_TYPE     = 3'd1;
    localparam logic [2:0] ROLE_LEN_LO   = 3'd2;
    localparam logic [2:0] ROLE_LEN_HI   = 3'd3;
    localparam logic [2:0] ROLE_DATA     = 3'd4;
    localparam logic [2:0] ROLE_TRAIL    = 3'd5;
    localparam logic [2:0] ROLE_AFTER_ER = 3'd6;

    // Status codes
    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_OK        = 3'd1;
    localparam logic [2:0] ST_BAD_VER   = 3'd2;
    localparam logic [2:0] ST_TOO_MANY  = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    // Header byte positions
    localparam logic [2:0] HDR_VERSION = 3'd0;
    localparam logic [2:0] HDR_KIND    = 3'd1;
    localparam logic [2:0] HDR_FLAGS   = 3'd2;
    localparam logic [2:0] HDR_TS0     = 3'd3;
    localparam logic [2:0] HDR_TS1     = 3'd4;
    localparam logic [2:0] HDR_TS2     = 3'd5;
    localparam logic [2:0] HDR_TS3     = 3'd6;
    localparam logic [2:0] HDR_COUNT   = 3'd7;

    localparam logic [7:0] VERSION_RESET = 8'd1;

    // One parsed result, core to output stage
    typedef struct packed {
        logic [2:0]  byte_role;
        logic [7:0]  out_byte;
        logic [7:0]  field_index;
        logic [7:0]  field_kind;
        logic [15:0] field_length;
        logic [15:0] data_offset;
        logic [7:0]  message_kind;
        logic [7:0]  message_flags;
        logic [31:0] timestamp;
        logic [7:0]  declared_fields;
        logic [2:0]  status;
        logic        message_done;
    } result_t;

endpackage

@@ rtl/tlv_message_parser.sv @@
// Top level of the streaming TLV message parser.
`timescale 1ns / 1ps

// Channel   Dir  Payload                                   Handshake
// s_*       in   tdata: in_byte; tlast: final_byte          s_tvalid / s_tready
// m_*       out  tdata: parsed fields; tuser: byte_role;    m_tvalid / m_tready
//                tlast: message_done
// cfg_*     in   cfg_data: expected_version                 cfg_valid / cfg_ready
//
// One byte per cycle: each accepted transaction updates the parser state and
// loads its result into the output register in the same edge.
// A result appears on the master side in the cycle after its byte is accepted.
// s_tready is high while the output register is empty or being drained, so a
// stall on m_tready holds the input back with no transaction lost.
// Reset (aresetn low, synchronous) clears the parser and sets
// expected_version to 1; cfg_ready is always high.

module tlv_message_parser #(
    parameter int MAX_FIELDS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input byte stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] in_byte
    input  logic         s_tlast,     // final_byte
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] out_byte, [15:8] field_index, [23:16] field_kind,
    // [39:24] field_length, [55:40] data_offset, [63:56] message_kind,
    // [71:64] message_flags, [103:72] timestamp, [111:104] declared_fields,
    // [114:112] status, [119:115] zero
    output logic [119:0] m_tdata,
    output logic [2:0]   m_tuser,     // [2:0] byte_role
    output logic         m_tlast,     // message_done
    // configuration write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data     // [7:0] expected_version
);

    tlvp_pkg::result_t result;
    logic              out_free;
    logic              accept;

    assign s_tready  = out_free;
    assign accept    = s_tvalid && out_free;
    assign cfg_ready = 1'b1;

    tlvp_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .in_byte    (s_tdata),
        .final_byte (s_tlast),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .result     (result)
    );

    tlvp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/tlvp_core.sv @@
// Parser state registers and the per-byte next-state / result logic.
`timescale 1ns / 1ps

module tlvp_core #(
    parameter int MAX_FIELDS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         in_byte,
    input  logic               final_byte,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    output tlvp_pkg::result_t  result
);

    localparam logic [7:0] MaxFields = 8'(MAX_FIELDS);

    tlvp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  hpos_reg, hpos_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] ts_reg, ts_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  index_reg, index_next;
    logic [7:0]  fkind_reg, fkind_next;
    logic [15:0] flen_reg, flen_next;
    logic [15:0] offset_reg, offset_next;
    logic [2:0]  err_reg, err_next;
    logic [7:0]  exp_ver_reg;

    logic [2:0]  role;
    logic [15:0] offset_out;
    logic [2:0]  status;
    logic [7:0]  index_inc;
    logic [16:0] offset_inc;

    assign index_inc  = index_reg + 8'd1;
    assign offset_inc = {1'b0, offset_reg} + 17'd1;

    always_comb begin
        phase_next   = phase_reg;
        hpos_next    = hpos_reg;
        version_next = version_reg;
        kind_next    = kind_reg;
        flags_next   = flags_reg;
        ts_next      = ts_reg;
        count_next   = count_reg;
        index_next   = index_reg;
        fkind_next   = fkind_reg;
        flen_next    = flen_reg;
        offset_next  = offset_reg;
        err_next     = err_reg;
        role         = tlvp_pkg::ROLE_AFTER_ER;
        offset_out   = 16'd0;

        case (phase_reg)
            tlvp_pkg::PH_HEADER: begin
                role = tlvp_pkg::ROLE_HEADER;
                case (hpos_reg)
                    tlvp_pkg::HDR_VERSION: version_next = in_byte;
                    tlvp_pkg::HDR_KIND:    kind_next    = in_byte;
                    tlvp_pkg::HDR_FLAGS:   flags_next   = in_byte;
                    tlvp_pkg::HDR_TS0:     ts_next      = ts_reg | {24'd0, in_byte};
                    tlvp_pkg::HDR_TS1:     ts_next      = ts_reg | {16'd0, in_byte, 8'd0};
                    tlvp_pkg::HDR_TS2:     ts_next      = ts_reg | {8'd0, in_byte, 16'd0};
                    tlvp_pkg::HDR_TS3:     ts_next      = ts_reg | {in_byte, 24'd0};
                    default:               count_next   = in_byte;
                endcase
                if (hpos_reg == tlvp_pkg::HDR_COUNT) begin
                    if (version_reg != exp_ver_reg) begin
                        err_next   = tlvp_pkg::ST_BAD_VER;
                        phase_next = tlvp_pkg::PH_ERROR;
                    end else if (in_byte > MaxFields) begin
                        err_next   = tlvp_pkg::ST_TOO_MANY;
                        phase_next = tlvp_pkg::PH_ERROR;
                    end else begin
                        index_next = 8'd0;
                        phase_next = (in_byte == 8'd0) ? tlvp_pkg::PH_TRAIL
                                                       : tlvp_pkg::PH_TYPE;
                    end
                end else begin
                    hpos_next = hpos_reg + 3'd1;
                end
            end
            tlvp_pkg::PH_TYPE: begin
                role        = tlvp_pkg::ROLE_TYPE;
                fkind_next  = in_byte;
                flen_next   = 16'd0;
                offset_next = 16'd0;
                phase_next  = tlvp_pkg::PH_LEN_LO;
            end
            tlvp_pkg::PH_LEN_LO: begin
                role       = tlvp_pkg::ROLE_LEN_LO;
                flen_next  = {8'd0, in_byte};
                phase_next = tlvp_pkg::PH_LEN_HI;
            end
            tlvp_pkg::PH_LEN_HI: begin
                role        = tlvp_pkg::ROLE_LEN_HI;
                flen_next   = {in_byte, flen_reg[7:0]};
                offset_next = 16'd0;
                if ({in_byte, flen_reg[7:0]} == 16'd0) begin
                    index_next = index_inc;
                    phase_next = (index_inc == count_reg) ? tlvp_pkg::PH_TRAIL
                                                          : tlvp_pkg::PH_TYPE;
                end else begin
                    phase_next = tlvp_pkg::PH_DATA;
                end
            end
            tlvp_pkg::PH_DATA: begin
                role       = tlvp_pkg::ROLE_DATA;
                offset_out = offset_reg;
                if (offset_inc >= {1'b0, flen_reg}) begin
                    offset_next = 16'd0;
                    index_next  = index_inc;
                    phase_next  = (index_inc == count_reg) ? tlvp_pkg::PH_TRAIL
                                                           : tlvp_pkg::PH_TYPE;
                end else begin
                    offset_next = offset_inc[15:0];
                end
            end
            tlvp_pkg::PH_TRAIL: role = tlvp_pkg::ROLE_TRAIL;
            default:            role = tlvp_pkg::ROLE_AFTER_ER;
        endcase

        if (err_next != tlvp_pkg::ST_BUSY) begin
            status = err_next;
        end else if (!final_byte) begin
            status = tlvp_pkg::ST_BUSY;
        end else if (phase_next == tlvp_pkg::PH_TRAIL) begin
            status = tlvp_pkg::ST_OK;
        end else begin
            status = tlvp_pkg::ST_TRUNCATED;
        end
    end

    always_comb begin
        result.byte_role       = role;
        result.out_byte        = in_byte;
        result.field_index     = index_next;
        result.field_kind      = fkind_next;
        result.field_length    = flen_next;
        result.data_offset     = offset_out;
        result.message_kind    = kind_next;
        result.message_flags   = flags_next;
        result.timestamp       = ts_next;
        result.declared_fields = count_next;
        result.status          = status;
        result.message_done    = final_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_ver_reg <= tlvp_pkg::VERSION_RESET;
        end else if (cfg_we) begin
            exp_ver_reg <= cfg_data;
        end
    end

    // Whole message state returns to reset after a final byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && final_byte)) begin
            phase_reg   <= tlvp_pkg::PH_HEADER;
            hpos_reg    <= 3'd0;
            version_reg <= 8'd0;
            kind_reg    <= 8'd0;
            flags_reg   <= 8'd0;
            ts_reg      <= 32'd0;
            count_reg   <= 8'd0;
            index_reg   <= 8'd0;
            fkind_reg   <= 8'd0;
            flen_reg    <= 16'd0;
            offset_reg  <= 16'd0;
            err_reg     <= tlvp_pkg::ST_BUSY;
        end else if (accept) begin
            phase_reg   <= phase_next;
            hpos_reg    <= hpos_next;
            version_reg <= version_next;
            kind_reg    <= kind_next;
            flags_reg   <= flags_next;
            ts_reg      <= ts_next;
            count_reg   <= count_next;
            index_reg   <= index_next;
            fkind_reg   <= fkind_next;
            flen_reg    <= flen_next;
            offset_reg  <= offset_next;
            err_reg     <= err_next;
        end
    end

endmodule

@@ rtl/tlvp_out_reg.sv @@
// Result register for the master stream; packs a result into tdata/tuser.
`timescale 1ns / 1ps

module tlvp_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  tlvp_pkg::result_t  result,
    output logic               free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [119:0]       m_tdata,
    output logic [2:0]         m_tuser,
    output logic               m_tlast
);

    logic               valid_reg;
    tlvp_pkg::result_t  data_reg;

    // Room when empty or the held transaction leaves this cycle
    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && free) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.byte_role;
    assign m_tlast  = data_reg.message_done;
    assign m_tdata  = {5'd0,
                       data_reg.status,
                       data_reg.declared_fields,
                       data_reg.timestamp,
                       data_reg.message_flags,
                       data_reg.message_kind,
                       data_reg.data_offset,
                       data_reg.field_length,
                       data_reg.field_kind,
                       data_reg.field_index,
                       data_reg.out_byte};

endmodule
